// ===== hw/rtl/srsl_pkg.sv =====
// shared types, constants and character helpers for the s-record stream loader
package srsl_pkg;

    // address width of write and start addresses
    localparam int ADDRESS_BITS = 32;
    localparam logic [31:0] ADDR_MASK = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << ADDRESS_BITS) - 64'd1);

    // queue between the character front and the record back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // stream widths
    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 64;
    localparam int M_TUSER_BITS = 7;

    // ascii codes
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // record kinds (digit after the S)
    localparam logic [3:0] KIND_S0 = 4'd0;
    localparam logic [3:0] KIND_S1 = 4'd1;
    localparam logic [3:0] KIND_S2 = 4'd2;
    localparam logic [3:0] KIND_S3 = 4'd3;
    localparam logic [3:0] KIND_S5 = 4'd5;
    localparam logic [3:0] KIND_S7 = 4'd7;
    localparam logic [3:0] KIND_S8 = 4'd8;
    localparam logic [3:0] KIND_S9 = 4'd9;

    // result word kinds
    typedef enum logic [2:0] {
        EV_WRITE     = 3'd0,
        EV_HEADER    = 3'd1,
        EV_REC_OK    = 3'd2,
        EV_REC_BAD   = 3'd3,
        EV_LOAD_DONE = 3'd4
    } event_t;

    // parser phases
    typedef enum logic [3:0] {
        PH_LINE  = 4'd0,
        PH_LINE2 = 4'd1,
        PH_KIND  = 4'd2,
        PH_COUNT = 4'd3,
        PH_ADDR  = 4'd4,
        PH_DATA  = 4'd5,
        PH_SUM   = 4'd6,
        PH_TAIL  = 4'd7,
        PH_SKIP  = 4'd8
    } phase_t;

    // one classified character
    typedef struct packed {
        logic [3:0] nib;      // hex value, or decimal value for digits
        logic       hex_ok;
        logic       is_dec;
        logic       kind_ok;
        logic       is_s;
        logic       is_cr;
        logic       is_lf;
        logic       is_ws;
    } chr_item_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // one result word
    typedef struct packed {
        event_t      event_res;
        logic [31:0] address;
        logic [7:0]  data;
        logic [3:0]  record_kind;
        logic        sum_ok;
        logic        start_valid;
        logic [15:0] record_total;
    } result_t;

    // kinds that end a load
    function automatic logic is_term(input logic [3:0] k);
        is_term = (k inside {KIND_S7, KIND_S8, KIND_S9});
    endfunction

    // number of address digits for a record kind
    function automatic logic [3:0] addr_digits(input logic [3:0] k);
        if (k inside {KIND_S2, KIND_S8})
            addr_digits = 4'd6;
        else if (k inside {KIND_S3, KIND_S7})
            addr_digits = 4'd8;
        else
            addr_digits = 4'd4;
    endfunction

    // sort one character into the classes the parser needs
    function automatic chr_item_t classify(input logic [7:0] ch);
        chr_item_t it;
        logic      dec;
        logic      alpha;
        dec   = (ch inside {[CH_0:CH_9]});
        alpha = (ch inside {[CH_LA:CH_LF_HEX], [CH_UA:CH_UF]});
        it.nib     = dec ? ch[3:0] : (alpha ? (ch[3:0] + 4'd9) : 4'd0);
        it.hex_ok  = dec || alpha;
        it.is_dec  = dec;
        it.kind_ok = dec && (ch[3:0] inside {KIND_S0, KIND_S1, KIND_S2, KIND_S3,
                                             KIND_S5, KIND_S7, KIND_S8, KIND_S9});
        it.is_s    = (ch == CH_S);
        it.is_cr   = (ch == CH_CR);
        it.is_lf   = (ch == CH_LF);
        it.is_ws   = (ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF});
        classify = it;
    endfunction

endpackage

// ===== hw/rtl/srsl_front.sv =====
// character front: takes input words, classifies them, feeds the queue
module srsl_front
    import srsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  ch,
    input  queue_stat_t q_stat,
    output logic        push,
    output chr_item_t   push_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    chr_item_t stage_item_reg;
    logic      accept;

    // stage is free or drains into the queue this cycle
    assign push    = stage_valid_reg && !q_stat.full;
    assign s_ready = !stage_valid_reg || !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign push_item = stage_item_reg;

    // stage occupancy
    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // classified character payload
    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= classify(ch);
    end

endmodule

// ===== hw/rtl/srsl_queue.sv =====
// short queue of classified characters between front and back
module srsl_queue
    import srsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  chr_item_t   push_item,
    input  logic        pop,
    output chr_item_t   head_item,
    output queue_stat_t q_stat
);

    chr_item_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign q_stat.full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_item    = entry_reg[rd_ptr_reg];

    // pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/srsl_back.sv =====
// record back: runs the s-record parser and holds the result word register
module srsl_back
    import srsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chr_item_t   head_item,
    input  queue_stat_t q_stat,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  kind_reg, kind_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [3:0]  digit_index_reg, digit_index_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [31:0] addr_acc_reg, addr_acc_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        bad_flag_reg, bad_flag_next;
    logic        sum_flag_reg, sum_flag_next;
    logic [31:0] start_reg, start_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg, out_res_next;

    logic        emit;
    logic        finish_req;
    result_t     res;
    logic [31:0] acc_shift;
    logic [7:0]  byte_val;
    logic [3:0]  digits;
    logic [7:0]  ab_plus1;
    logic [3:0]  di_inc;
    logic        hdr_ok;

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    // parser step and result word
    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        high_nibble_next = high_nibble_reg;
        digit_index_next = digit_index_reg;
        byte_count_next  = byte_count_reg;
        addr_acc_next    = addr_acc_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        bad_flag_next    = bad_flag_reg;
        sum_flag_next    = sum_flag_reg;
        start_next       = start_reg;
        emit             = 1'b0;
        finish_req       = 1'b0;
        res              = '0;
        res.event_res    = EV_WRITE;
        res.record_kind  = kind_reg;

        pop       = !q_stat.empty && (!out_valid_reg || m_ready);
        acc_shift = {addr_acc_reg[27:0], head_item.nib};
        byte_val  = {high_nibble_reg, head_item.nib};
        digits    = addr_digits(kind_reg);
        ab_plus1  = {5'd0, digits[3:1]} + 8'd1;
        di_inc    = digit_index_reg + 4'd1;

        // count and address limits for the header
        if (kind_reg == KIND_S0)
            hdr_ok = (byte_count_reg >= 8'd3) && (acc_shift == '0);
        else if (kind_reg == KIND_S5)
            hdr_ok = (byte_count_reg == 8'd3);
        else if (is_term(kind_reg))
            hdr_ok = (byte_count_reg == ab_plus1);
        else
            hdr_ok = (byte_count_reg >= ab_plus1);

        if (pop)
        begin
            case (phase_reg)
                PH_LINE, PH_LINE2:
                begin
                    if (head_item.is_s)
                    begin
                        kind_next        = '0;
                        high_nibble_next = '0;
                        digit_index_next = '0;
                        byte_count_next  = '0;
                        addr_acc_next    = '0;
                        bytes_left_next  = '0;
                        running_sum_next = '0;
                        bad_flag_next    = 1'b0;
                        sum_flag_next    = 1'b0;
                        phase_next       = PH_KIND;
                    end
                    else if (head_item.is_cr)
                    begin
                        bad_flag_next = 1'b1;
                        finish_req    = 1'b1;
                    end
                    else if (head_item.is_lf && phase_reg == PH_LINE)
                        phase_next = PH_LINE2;
                    else
                    begin
                        bad_flag_next = 1'b1;
                        phase_next    = PH_SKIP;
                    end
                end
                PH_KIND:
                begin
                    kind_next = head_item.is_dec ? head_item.nib : 4'd0;
                    if (head_item.kind_ok)
                    begin
                        digit_index_next = '0;
                        phase_next       = PH_COUNT;
                    end
                    else
                    begin
                        bad_flag_next = 1'b1;
                        if (head_item.is_cr)
                            finish_req = 1'b1;
                        else
                            phase_next = PH_SKIP;
                    end
                end
                PH_ADDR:
                begin
                    if (!head_item.hex_ok)
                    begin
                        bad_flag_next = 1'b1;
                        if (head_item.is_cr)
                            finish_req = 1'b1;
                        else
                            phase_next = PH_SKIP;
                    end
                    else
                    begin
                        addr_acc_next    = acc_shift;
                        digit_index_next = di_inc;
                        if (digit_index_reg[0])
                            running_sum_next = running_sum_reg + acc_shift[7:0];
                        // last address digit: check the header
                        if (di_inc >= digits)
                        begin
                            if (!hdr_ok)
                            begin
                                bad_flag_next = 1'b1;
                                phase_next    = PH_SKIP;
                            end
                            else
                            begin
                                bytes_left_next = byte_count_reg - ab_plus1;
                                if (kind_reg inside {KIND_S1, KIND_S2, KIND_S3})
                                    addr_acc_next = acc_shift & ADDR_MASK;
                                digit_index_next = '0;
                                phase_next = (byte_count_reg != ab_plus1) ? PH_DATA : PH_SUM;
                            end
                        end
                    end
                end
                PH_COUNT, PH_DATA, PH_SUM:
                begin
                    if (!head_item.hex_ok)
                    begin
                        bad_flag_next = 1'b1;
                        if (head_item.is_cr)
                            finish_req = 1'b1;
                        else
                            phase_next = PH_SKIP;
                    end
                    else if (!digit_index_reg[0])
                    begin
                        high_nibble_next = head_item.nib;
                        digit_index_next = 4'd1;
                    end
                    else
                    begin
                        digit_index_next = '0;
                        if (phase_reg == PH_COUNT)
                        begin
                            byte_count_next  = byte_val;
                            running_sum_next = running_sum_reg + byte_val;
                            addr_acc_next    = '0;
                            phase_next       = PH_ADDR;
                        end
                        else if (phase_reg == PH_DATA)
                        begin
                            running_sum_next = running_sum_reg + byte_val;
                            bytes_left_next  = bytes_left_reg - 8'd1;
                            if (bytes_left_reg == 8'd1)
                                phase_next = PH_SUM;
                            emit     = 1'b1;
                            res.data = byte_val;
                            if (kind_reg == KIND_S0)
                                res.event_res = EV_HEADER;
                            else
                            begin
                                res.event_res = EV_WRITE;
                                res.address   = addr_acc_reg & ADDR_MASK;
                                addr_acc_next = (addr_acc_reg + 32'd1) & ADDR_MASK;
                            end
                        end
                        else
                        begin
                            // checksum byte
                            sum_flag_next = (~running_sum_reg == byte_val);
                            if ((~running_sum_reg != byte_val) && kind_reg != KIND_S0 &&
                                !is_term(kind_reg))
                                bad_flag_next = 1'b1;
                            phase_next = PH_TAIL;
                        end
                    end
                end
                PH_TAIL:
                begin
                    if (head_item.is_cr)
                        finish_req = 1'b1;
                    else if (!head_item.is_ws)
                        bad_flag_next = 1'b1;
                end
                default:
                begin
                    if (head_item.is_cr)
                    begin
                        bad_flag_next = 1'b1;
                        finish_req    = 1'b1;
                    end
                    else
                        phase_next = PH_SKIP;
                end
            endcase
        end

        // end of record: report and clear
        if (finish_req)
        begin
            emit            = 1'b1;
            res             = '0;
            res.record_kind = kind_next;
            res.sum_ok      = sum_flag_reg;
            if (bad_flag_next)
                res.event_res = EV_REC_BAD;
            else if (is_term(kind_next))
            begin
                res.event_res   = EV_LOAD_DONE;
                res.start_valid = sum_flag_reg;
                if (sum_flag_reg)
                begin
                    start_next  = addr_acc_reg & ADDR_MASK;
                    res.address = addr_acc_reg & ADDR_MASK;
                end
                else
                    res.address = start_reg;
            end
            else
            begin
                res.event_res = EV_REC_OK;
                if (kind_next == KIND_S5)
                    res.record_total = addr_acc_reg[15:0];
            end
            phase_next       = PH_LINE;
            kind_next        = '0;
            high_nibble_next = '0;
            digit_index_next = '0;
            byte_count_next  = '0;
            addr_acc_next    = '0;
            bytes_left_next  = '0;
            running_sum_next = '0;
            bad_flag_next    = 1'b0;
            sum_flag_next    = 1'b0;
        end

        // result word register
        out_res_next = out_res_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LINE;
            kind_reg        <= '0;
            high_nibble_reg <= '0;
            digit_index_reg <= '0;
            byte_count_reg  <= '0;
            addr_acc_reg    <= '0;
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
            bad_flag_reg    <= 1'b0;
            sum_flag_reg    <= 1'b0;
            start_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            high_nibble_reg <= high_nibble_next;
            digit_index_reg <= digit_index_next;
            byte_count_reg  <= byte_count_next;
            addr_acc_reg    <= addr_acc_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
            bad_flag_reg    <= bad_flag_next;
            sum_flag_reg    <= sum_flag_next;
            start_reg       <= start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

// ===== hw/rtl/srecord_stream_loader_unit.sv =====
// top level of the s-record stream loader: front, queue and back
//
//   channel   dir   tdata                 tuser
//   s_axis    in    [7:0] ch              -
//   m_axis    out   address/data/flags    event_res, record_kind
//
// one character word is taken per cycle and one result word leaves per cycle
// at most; a character passes the front stage and a queue entry before the
// parser loads its result word into the result register, and the parser takes
// one character a cycle unless the result register is full and m_axis stalls.
// rst_n clears all parser state, the queue and the start address.
// a stalled m_axis side fills the result register, then the four-entry queue
// and the front stage before s_axis_tready drops.
module srecord_stream_loader_unit
    import srsl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,   // [7:0] ch
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [31:0] address, [39:32] data, [40] sum_ok, [41] start_valid,
    // [57:42] record_total, [63:58] zero
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,
    output logic [M_TUSER_BITS-1:0] m_axis_tuser    // [2:0] event_res, [6:3] record_kind
);

    queue_stat_t q_stat;
    logic        q_push;
    logic        q_pop;
    chr_item_t   push_item;
    chr_item_t   head_item;
    result_t     out_res;

    // character front
    srsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .ch        (s_axis_tdata),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_item (push_item)
    );

    // character queue
    srsl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // record parser
    srsl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (out_res)
    );

    // result word packing
    assign m_axis_tdata = {6'd0, out_res.record_total, out_res.start_valid, out_res.sum_ok,
                           out_res.data, out_res.address};
    assign m_axis_tuser = {out_res.record_kind, out_res.event_res};

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_start_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res.event_res != EV_LOAD_DONE) |-> !out_res.start_valid)
        else $error("start flag outside load done");

    a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res.event_res == EV_LOAD_DONE) |->
            (out_res.start_valid == out_res.sum_ok))
        else $error("load done start flag differs from checksum flag");
`endif

endmodule
